[hw/rtl/rpae_pkg.sv]
// Shared types, constants and helper functions for the RGB to ANSI text encoder.
// No dependencies; used by every module of the block.
package rpae_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 128;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int FW_W       = 10;
  localparam int FH_W       = 8;
  localparam logic [FW_W-1:0] FW_RESET = 10'd384;
  localparam logic [FH_W-1:0] FH_RESET = 8'd108;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Luma arithmetic: Y = (2126r + 7152g + 722b + 5000) / 10000
  localparam int SUM_W      = 22;
  localparam int LUMA_KR    = 2126;
  localparam int LUMA_KG    = 7152;
  localparam int LUMA_KB    = 722;
  localparam int LUMA_RND   = 5000;
  localparam int LUMA_MUL   = 6871948;   // ceil(2^36 / 10000), exact for sums below 2^24
  localparam int LUMA_SHIFT = 36;
  localparam int LPROD_W    = 45;
  // index = (63Y + 127) / 255
  localparam int VW        = 14;
  localparam int IDX_RND   = 127;
  localparam int IDX_MUL   = 16449;     // ceil(2^22 / 255), exact below 21960
  localparam int IDX_SHIFT = 22;
  localparam int IPW       = 29;

  // Text bytes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_EIGHT = 8'h38;

  // Density ramp, darkest first
  localparam logic [7:0] RAMP [64] = '{
    8'h20, 8'h2E, 8'h60, 8'h27, 8'h3A, 8'h5F, 8'h3B, 8'h5E,
    8'h21, 8'h7E, 8'h22, 8'h3C, 8'h3E, 8'h2F, 8'h5C, 8'h3D,
    8'h2A, 8'h3F, 8'h7C, 8'h76, 8'h4C, 8'h78, 8'h54, 8'h6C,
    8'h59, 8'h7A, 8'h72, 8'h69, 8'h6E, 8'h4A, 8'h6A, 8'h46,
    8'h49, 8'h65, 8'h56, 8'h58, 8'h79, 8'h5A, 8'h53, 8'h68,
    8'h34, 8'h6B, 8'h55, 8'h77, 8'h50, 8'h35, 8'h4B, 8'h62,
    8'h6D, 8'h48, 8'h39, 8'h25, 8'h47, 8'h4F, 8'h23, 8'h38,
    8'h30, 8'h67, 8'h4D, 8'h42, 8'h57, 8'h24, 8'h51, 8'h40
  };

  // One colour component in decimal; first is the index of the leading digit
  // (0 hundreds, 1 tens, 2 ones)
  typedef struct packed {
    logic [1:0] first;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } rpae_dec_t;

  // Queue entry: everything the back end needs to print one pixel
  typedef struct packed {
    rpae_dec_t [2:0] comp;       // [0] red, [1] green, [2] blue
    logic [7:0]      glyph;
    logic            row_end;
    logic            frame_end;
  } rpae_item_t;

  typedef struct packed {
    logic           head_valid;
    logic [QCW-1:0] count;
  } rpae_qstat_t;

  typedef enum logic [2:0] {
    BK_PREFIX,
    BK_DIGIT,
    BK_SEP,
    BK_GLYPH,
    BK_TAIL,
    BK_NL,
    BK_HOME
  } rpae_bk_state_t;

  function automatic rpae_dec_t dec_of(input logic [7:0] v);
    rpae_dec_t   d;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [6:0]  tens10;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      rem    = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      rem    = 7'(v - 8'd100);
    end else begin
      d.hund = 4'd0;
      rem    = v[6:0];
    end
    tprod  = 15'(rem) * 15'd205;        // rem * 205 >> 11 == rem / 10 for rem < 100
    d.tens = tprod[14:11];
    tens10 = 7'({d.tens, 3'b000}) + 7'({d.tens, 1'b0});
    d.ones = 4'(rem - tens10);
    if (v >= 8'd100) begin
      d.first = 2'd0;
    end else if (v >= 8'd10) begin
      d.first = 2'd1;
    end else begin
      d.first = 2'd2;
    end
    return d;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [2:0] sub);
    logic [7:0] b;
    unique case (sub)
      3'd0:    b = CH_ESC;
      3'd1:    b = CH_LBR;
      3'd2:    b = CH_THREE;
      3'd3:    b = CH_EIGHT;
      3'd4:    b = CH_SEMI;
      3'd5:    b = CH_TWO;
      3'd6:    b = CH_SEMI;
      default: b = CH_ESC;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/rpae_front.sv]
// Front end: input handshake, row/frame counting, luma pipeline and digit split.
// Depends on rpae_pkg. Holds a credit count so the queue can never overflow.
module rpae_front #(
  parameter int MAX_WIDTH  = rpae_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rpae_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rpae_pkg::FW_W-1:0]   frame_width,
  input  logic [rpae_pkg::FH_W-1:0]   frame_height,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic                        pop,
  output logic                        push,
  output rpae_pkg::rpae_item_t        push_item
);

  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP = ($clog2(MAX_WIDTH + 1) > rpae_pkg::FW_W) ?
                        $clog2(MAX_WIDTH + 1) : rpae_pkg::FW_W;
  localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > rpae_pkg::FH_W) ?
                        $clog2(MAX_HEIGHT + 1) : rpae_pkg::FH_W;

  logic [COLW-1:0]          col_r, col_nxt;
  logic [ROWW-1:0]          row_r, row_nxt;
  logic [rpae_pkg::QCW-1:0] credit_r, credit_nxt;
  logic                     va_r, vb_r, vc_r, vd_r;

  logic [WCMP-1:0] fw_ext, width_eff, col_inc;
  logic [HCMP-1:0] fh_ext, height_eff, row_inc;
  logic            accept, row_end, frame_end;

  // stage payloads
  logic [7:0]                  red_a_r, green_a_r, blue_a_r;
  rpae_pkg::rpae_item_t        item_a_r, item_b_r, item_c_r, item_d_r;
  rpae_pkg::rpae_item_t        item_c_glyph;
  logic [rpae_pkg::SUM_W-1:0]  sum_b_r;
  logic [7:0]                  luma_c_r;
  logic [rpae_pkg::LPROD_W-1:0] lprod;
  logic [rpae_pkg::VW-1:0]     vsum;
  logic [rpae_pkg::IPW-1:0]    iprod;
  logic [5:0]                  idx;

  assign accept = in_valid && in_ready;
  assign in_ready = (credit_r != '0);

  // effective limits: zero reads as one, above the maximum saturates
  always_comb begin
    fw_ext = WCMP'(frame_width);
    fh_ext = HCMP'(frame_height);
    if (fw_ext == '0) begin
      width_eff = WCMP'(1);
    end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
    if (fh_ext == '0) begin
      height_eff = HCMP'(1);
    end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
      height_eff = HCMP'(MAX_HEIGHT);
    end else begin
      height_eff = fh_ext;
    end
    col_inc   = WCMP'(col_r) + WCMP'(1);
    row_inc   = HCMP'(row_r) + HCMP'(1);
    row_end   = (col_inc >= width_eff);
    frame_end = row_end && (row_inc >= height_eff);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      col_nxt = row_end ? '0 : COLW'(col_inc);
      if (row_end) begin
        row_nxt = frame_end ? '0 : ROWW'(row_inc);
      end
    end
    credit_nxt = credit_r - rpae_pkg::QCW'(accept) + rpae_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      credit_r <= rpae_pkg::QCW'(rpae_pkg::QDEPTH);
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
      vd_r     <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      credit_r <= credit_nxt;
      va_r     <= accept;
      vb_r     <= va_r;
      vc_r     <= vb_r;
      vd_r     <= vc_r;
    end
  end

  // luma: weighted sum, reciprocal divide, then ramp index
  assign lprod = rpae_pkg::LPROD_W'(sum_b_r + rpae_pkg::SUM_W'(rpae_pkg::LUMA_RND)) *
                 rpae_pkg::LPROD_W'(rpae_pkg::LUMA_MUL);
  assign vsum  = rpae_pkg::VW'({luma_c_r, 6'b000000}) - rpae_pkg::VW'(luma_c_r) +
                 rpae_pkg::VW'(rpae_pkg::IDX_RND);
  assign iprod = rpae_pkg::IPW'(vsum) * rpae_pkg::IPW'(rpae_pkg::IDX_MUL);
  assign idx   = iprod[rpae_pkg::IDX_SHIFT +: 6];

  // last stage descriptor with its glyph filled in
  always_comb begin
    item_c_glyph       = item_c_r;
    item_c_glyph.glyph = rpae_pkg::RAMP[idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_a_r            <= in_red;
      green_a_r          <= in_green;
      blue_a_r           <= in_blue;
      item_a_r.comp      <= {rpae_pkg::dec_of(in_blue), rpae_pkg::dec_of(in_green),
                             rpae_pkg::dec_of(in_red)};
      item_a_r.glyph     <= '0;
      item_a_r.row_end   <= row_end;
      item_a_r.frame_end <= frame_end;
    end
    sum_b_r  <= rpae_pkg::SUM_W'(red_a_r)   * rpae_pkg::SUM_W'(rpae_pkg::LUMA_KR) +
                rpae_pkg::SUM_W'(green_a_r) * rpae_pkg::SUM_W'(rpae_pkg::LUMA_KG) +
                rpae_pkg::SUM_W'(blue_a_r)  * rpae_pkg::SUM_W'(rpae_pkg::LUMA_KB);
    item_b_r <= item_a_r;
    luma_c_r <= lprod[rpae_pkg::LUMA_SHIFT +: 8];
    item_c_r <= item_b_r;
    item_d_r <= item_c_glyph;
  end

  assign push      = vd_r;
  assign push_item = item_d_r;

endmodule

[hw/rtl/rpae_queue.sv]
// Small register FIFO of pixel descriptors between front and back ends.
// Depends on rpae_pkg for the entry type and depth.
module rpae_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rpae_pkg::rpae_item_t   push_item,
  input  logic                   pop,
  output rpae_pkg::rpae_item_t   head,
  output rpae_pkg::rpae_qstat_t  stat
);

  rpae_pkg::rpae_item_t     mem_r [rpae_pkg::QDEPTH];
  logic [rpae_pkg::QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [rpae_pkg::QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= rpae_pkg::QPW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= rpae_pkg::QPW'(rd_ptr_r + 1'b1);
      end
      count_r <= count_r + rpae_pkg::QCW'(push) - rpae_pkg::QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head            = mem_r[rd_ptr_r];
  assign stat.head_valid = (count_r != '0);
  assign stat.count      = count_r;

endmodule

[hw/rtl/rpae_back.sv]
// Back end: byte sequencer that spells out one descriptor, plus the output register.
// Depends on rpae_pkg. Pops the queue on the last byte of each pixel.
module rpae_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpae_pkg::rpae_item_t   head,
  input  rpae_pkg::rpae_qstat_t  stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_text_byte,
  output logic                   out_last_of_run
);

  rpae_pkg::rpae_bk_state_t state_r, state_nxt;
  logic [2:0]               sub_r, sub_nxt;
  logic [1:0]               col_r, col_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               byte_r;
  logic                     last_r;
  logic [7:0]               byte_c;
  logic                     last_c, step;
  rpae_pkg::rpae_dec_t      cur;
  logic [3:0]               digit;

  assign step = stat.head_valid && (!out_valid_r || out_ready);
  assign pop  = step && last_c;
  assign cur  = head.comp[col_r];

  always_comb begin
    unique case (sub_r[1:0])
      2'd0:    digit = cur.hund;
      2'd1:    digit = cur.tens;
      default: digit = cur.ones;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    col_nxt   = col_r;
    byte_c    = rpae_pkg::CH_ESC;
    last_c    = 1'b0;
    unique case (state_r)
      rpae_pkg::BK_PREFIX: begin
        byte_c = rpae_pkg::prefix_byte(sub_r);
        if (sub_r == 3'd6) begin
          state_nxt = rpae_pkg::BK_DIGIT;
          col_nxt   = 2'd0;
          sub_nxt   = {1'b0, head.comp[0].first};
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      rpae_pkg::BK_DIGIT: begin
        byte_c = rpae_pkg::CH_ZERO + {4'b0000, digit};
        if (sub_r >= 3'd2) begin
          state_nxt = rpae_pkg::BK_SEP;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      rpae_pkg::BK_SEP: begin
        if (col_r == 2'd2) begin
          byte_c    = rpae_pkg::CH_M;
          state_nxt = rpae_pkg::BK_GLYPH;
        end else begin
          byte_c    = rpae_pkg::CH_SEMI;
          col_nxt   = 2'(col_r + 2'd1);
          sub_nxt   = {1'b0, head.comp[2'(col_r + 2'd1)].first};
          state_nxt = rpae_pkg::BK_DIGIT;
        end
      end
      rpae_pkg::BK_GLYPH: begin
        byte_c    = head.glyph;
        sub_nxt   = 3'd0;
        state_nxt = rpae_pkg::BK_TAIL;
      end
      rpae_pkg::BK_TAIL: begin
        unique case (sub_r[1:0])
          2'd0:    byte_c = rpae_pkg::CH_ESC;
          2'd1:    byte_c = rpae_pkg::CH_LBR;
          2'd2:    byte_c = rpae_pkg::CH_ZERO;
          default: byte_c = rpae_pkg::CH_M;
        endcase
        if (sub_r >= 3'd3) begin
          sub_nxt = 3'd0;
          if (head.row_end) begin
            state_nxt = rpae_pkg::BK_NL;
          end else begin
            last_c    = 1'b1;
            state_nxt = rpae_pkg::BK_PREFIX;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      rpae_pkg::BK_NL: begin
        byte_c  = rpae_pkg::CH_NL;
        sub_nxt = 3'd0;
        if (head.frame_end) begin
          state_nxt = rpae_pkg::BK_HOME;
        end else begin
          last_c    = 1'b1;
          state_nxt = rpae_pkg::BK_PREFIX;
        end
      end
      rpae_pkg::BK_HOME: begin
        unique case (sub_r[1:0])
          2'd0:    byte_c = rpae_pkg::CH_ESC;
          2'd1:    byte_c = rpae_pkg::CH_LBR;
          default: byte_c = rpae_pkg::CH_H;
        endcase
        if (sub_r >= 3'd2) begin
          last_c    = 1'b1;
          sub_nxt   = 3'd0;
          state_nxt = rpae_pkg::BK_PREFIX;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      default: begin
        state_nxt = rpae_pkg::BK_PREFIX;
        sub_nxt   = 3'd0;
      end
    endcase
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpae_pkg::BK_PREFIX;
      sub_r       <= 3'd0;
      col_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        state_r <= state_nxt;
        sub_r   <= sub_nxt;
        col_r   <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= byte_c;
      last_r <= last_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_byte   = byte_r;
  assign out_last_of_run = last_r;

endmodule

[hw/rtl/rgb_pixel_to_ansi_ascii_encoder_core.sv]
// Top level of the RGB pixel to ANSI truecolour text encoder.
// Depends on rpae_pkg, rpae_front, rpae_queue and rpae_back.
//
// Takes one RGB24 pixel per input beat in raster order and produces the terminal text for it,
// one byte per output beat: ESC[38;2;R;G;Bm, a glyph picked from a 64-step density ramp by
// rounded Rec.709 luma, then ESC[0m; a newline follows the last pixel of each row and ESC[H
// the newline of the last row of a frame. last_of_run marks the final byte of each pixel.
// A pixel gives 18 to 24 bytes, up to 28 at a frame end; the back-end byte sequencer emits
// exactly one byte per cycle while the sink is ready and a descriptor is queued, with no gap
// between pixels. The front end carries each pixel through its stage registers a, b, c and d
// to a descriptor and takes a new pixel whenever the 8-entry descriptor queue has room,
// so input beats may arrive back to back until it fills. Width and height are written on the
// cfg_ port (index 0 width, 1 height; other indices ignored, zero reads as one, values above
// MAX_WIDTH/MAX_HEIGHT saturate); write them only while the block is idle.

module rgb_pixel_to_ansi_ascii_encoder_core #(
  parameter int MAX_WIDTH  = rpae_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rpae_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_text_byte,
  output logic                            out_last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpae_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [rpae_pkg::FW_W-1:0] fw_r;
  logic [rpae_pkg::FH_W-1:0] fh_r;
  logic                      push, pop;
  rpae_pkg::rpae_item_t      push_item, head;
  rpae_pkg::rpae_qstat_t     q_stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rpae_pkg::FW_RESET;
      fh_r <= rpae_pkg::FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rpae_pkg::CFG_FRAME_WIDTH) begin
        fw_r <= cfg_data[rpae_pkg::FW_W-1:0];
      end else if (cfg_index == rpae_pkg::CFG_FRAME_HEIGHT) begin
        fh_r <= cfg_data[rpae_pkg::FH_W-1:0];
      end
    end
  end

  // Front end: counts columns/rows at the input beat, works out luma and digits
  rpae_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .pop          (pop),
    .push         (push),
    .push_item    (push_item)
  );

  // Descriptor queue; space is reserved by the front end's credit count
  rpae_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back end: spells the head descriptor out byte by byte
  rpae_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .stat            (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_byte   (out_text_byte),
    .out_last_of_run (out_last_of_run)
  );

  // Credits must keep the queue within its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= rpae_pkg::QCW'(rpae_pkg::QDEPTH))
    else $error("descriptor queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (q_stat.count < rpae_pkg::QCW'(rpae_pkg::QDEPTH)))
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.head_valid)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule
